// ===== rtl/core/bct_pkg.sv =====
package bct_pkg;

    // field widths of the item and result channels
    localparam int COORD_W = 9;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register select, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // image size after reset
    localparam logic [COORD_W-1:0] SIZE_RESET = 9'd256;

    // item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // walker heading, +1 is a left turn
    typedef enum logic [1:0] {
        HD_EAST  = 2'd0,
        HD_NORTH = 2'd1,
        HD_WEST  = 2'd2,
        HD_SOUTH = 2'd3
    } t_heading;

    // progress of the trace
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRACE = 2'd1,
        PH_CLOSE = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // control sequencer
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_STEP = 4'b0100,
        S_TURN = 4'b1000
    } t_state;

endpackage

// ===== rtl/core/bct_ifs.sv =====
// item channel: pixel writes and step requests
interface bct_in_if import bct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               pixel_black;

    modport source (output valid, opcode, pixel_x, pixel_y, pixel_black, input ready);
    modport sink   (input valid, opcode, pixel_x, pixel_y, pixel_black, output ready);
endinterface

// result channel: contour corner points
interface bct_out_if import bct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               found;
    logic               last;

    modport source (output valid, point_x, point_y, found, last, input ready);
    modport sink   (input valid, point_x, point_y, found, last, output ready);
endinterface

// ===== rtl/core/bct_ram.sv =====
module bct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/core/binary_contour_tracer.sv =====
// binary contour tracer
// holds a black/white image in one bit-wide memory and follows the outer
// boundary of the first object, one corner point per step item.
// item channel (i_item): opcode write stores pixel_black at (pixel_x,
// pixel_y), one-based; opcode step asks for the next corner point.
// result channel (o_point): at most one transfer per step, none per write;
// found=0 with last=1 marks an empty image, last=1 the closing point.
// a step moves the walker, reads the two pixels ahead together through the
// memory's two read ports, then makes the turn on the registered read data.
// the first step of a trace also runs a raster scan at one pixel position
// per cycle; its point comes up after the scan.
// the configuration port sets image_width / image_height (apb, addr 0/4);
// any pixel or register write cancels a trace in progress.
// reset sets the size to 256 x 256 and the trace to idle; the image memory
// is not cleared and every pixel must be written before it is traced.
// while a result waits for o_point.ready, further items are held off.
module binary_contour_tracer import bct_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bct_in_if.sink                i_item,
    bct_out_if.source             o_point,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int AW    = XB + YB;
    localparam int MB    = (XB > YB) ? XB : YB;
    localparam int CW    = ((MB > COORD_W) ? MB : COORD_W) + 2;
    localparam int DEPTH = 1 << AW;

    localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MAX_H_C = CW'(MAX_HEIGHT);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // pixel address from one-based coordinates
    function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] px,
                                               input logic [CW-1:0] py);
        logic [CW-1:0] xm;
        logic [CW-1:0] ym;
        xm = px - ONE_C;
        ym = py - ONE_C;
        return {ym[YB-1:0], xm[XB-1:0]};
    endfunction

    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    t_heading             r_heading, n_heading;
    logic [COORD_W-1:0]   r_width, n_width;
    logic [COORD_W-1:0]   r_height, n_height;
    logic [COORD_W-1:0]   r_wx, n_wx;
    logic [COORD_W-1:0]   r_wy, n_wy;
    logic [COORD_W-1:0]   r_start_x, n_start_x;
    logic [COORD_W-1:0]   r_start_y, n_start_y;
    logic [CW-1:0]        r_sx, n_sx;
    logic [CW-1:0]        r_sy, n_sy;
    logic [CW-1:0]        r_cx, n_cx;
    logic [CW-1:0]        r_cy, n_cy;
    logic                 r_chk, n_chk;
    logic                 r_chk_last, n_chk_last;
    logic                 r_up_in, n_up_in;
    logic                 r_issue_done, n_issue_done;
    logic                 r_l_in, n_l_in;
    logic                 r_r_in, n_r_in;
    logic                 r_out_valid, n_out_valid;
    logic [COORD_W-1:0]   r_out_x, n_out_x;
    logic [COORD_W-1:0]   r_out_y, n_out_y;
    logic                 r_out_found, n_out_found;
    logic                 r_out_last, n_out_last;

    logic [CW-1:0]        eff_w, eff_h, ext_w, ext_h;
    logic [CW-1:0]        wr_x, wr_y;
    logic                 in_acc, cfg_wr, do_step, wr_en;
    logic [COORD_W-1:0]   nx, ny;
    logic [CW-1:0]        ex, ey, lx, ly, rx, ry;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic                 rd_a, rd_b, hit, left_blk, right_blk;
    logic [1:0]           turned;

    // handshakes
    assign in_acc       = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE) && (!r_out_valid || o_point.ready);
    assign cfg_wr       = psel && penable && pwrite;
    assign pready       = 1'b1;

    // register readback
    assign prdata = (paddr[2] == REG_HEIGHT) ? APB_DATA_W'(r_height) : APB_DATA_W'(r_width);

    // image size clipped to the memory
    assign ext_w = CW'(r_width);
    assign ext_h = CW'(r_height);
    assign eff_w = (ext_w > MAX_W_C) ? MAX_W_C : ext_w;
    assign eff_h = (ext_h > MAX_H_C) ? MAX_H_C : ext_h;

    // pixel write port
    assign wr_x  = CW'(i_item.pixel_x);
    assign wr_y  = CW'(i_item.pixel_y);
    assign wr_en = in_acc && (i_item.opcode == OP_WRITE)
                && (wr_x != '0) && (wr_x <= MAX_W_C)
                && (wr_y != '0) && (wr_y <= MAX_H_C);

    // one walker move: a step on the accepted item or right after the scan
    assign do_step = (in_acc && (i_item.opcode == OP_STEP) && (r_phase == PH_TRACE))
                  || (r_state == S_STEP);

    // walker advance and the two pixels ahead
    always_comb begin
        nx = r_wx;
        ny = r_wy;
        unique case (r_heading)
            HD_EAST:  nx = r_wx + 9'd1;
            HD_NORTH: ny = r_wy - 9'd1;
            HD_WEST:  nx = r_wx - 9'd1;
            HD_SOUTH: ny = r_wy + 9'd1;
        endcase
        ex = CW'(nx);
        ey = CW'(ny);
        lx = ex;
        ly = ey;
        rx = ex;
        ry = ey;
        unique case (r_heading)
            HD_EAST: begin
                lx = ex + ONE_C; ly = ey;
                rx = ex + ONE_C; ry = ey + ONE_C;
            end
            HD_NORTH: begin
                lx = ex;         ly = ey;
                rx = ex + ONE_C; ry = ey;
            end
            HD_WEST: begin
                lx = ex;         ly = ey + ONE_C;
                rx = ex;         ry = ey;
            end
            HD_SOUTH: begin
                lx = ex + ONE_C; ly = ey + ONE_C;
                rx = ex;         ry = ey + ONE_C;
            end
        endcase
    end

    // read addresses: scan position and its upper neighbor, or the pixels ahead
    assign raddr_a = (r_state == S_SCAN) ? pix_addr(r_sx, r_sy) : pix_addr(lx, ly);
    assign raddr_b = (r_state == S_SCAN) ? pix_addr(r_sx, r_sy - ONE_C) : pix_addr(rx, ry);

    bct_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (pix_addr(wr_x, wr_y)),
        .i_wdata   (i_item.pixel_black),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rd_b)
    );

    // scan hit and turn decision on the registered read data
    assign hit       = r_chk && rd_a && !(rd_b && r_up_in);
    assign left_blk  = r_l_in && rd_a;
    assign right_blk = r_r_in && rd_b;
    assign turned    = left_blk ? (r_heading + 2'd1)
                     : (!right_blk ? (r_heading + 2'd3) : r_heading);

    // sequencer and datapath next state
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_heading    = r_heading;
        n_width      = r_width;
        n_height     = r_height;
        n_wx         = r_wx;
        n_wy         = r_wy;
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_chk        = r_chk;
        n_chk_last   = r_chk_last;
        n_up_in      = r_up_in;
        n_issue_done = r_issue_done;
        n_l_in       = r_l_in;
        n_r_in       = r_r_in;
        n_out_valid  = r_out_valid && !o_point.ready;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_found  = r_out_found;
        n_out_last   = r_out_last;

        // emit the current corner, move, look ahead
        if (do_step) begin
            n_out_valid = 1'b1;
            n_out_x     = r_wx;
            n_out_y     = r_wy;
            n_out_found = 1'b1;
            n_out_last  = 1'b0;
            n_wx        = nx;
            n_wy        = ny;
            n_l_in      = (lx != '0) && (ly != '0) && (lx <= eff_w) && (ly <= eff_h);
            n_r_in      = (rx != '0) && (ry != '0) && (rx <= eff_w) && (ry <= eff_h);
            n_state     = S_TURN;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_item.opcode == OP_WRITE)) begin
                    n_phase = PH_IDLE;
                end else if (in_acc) begin
                    unique case (r_phase)
                        PH_IDLE: begin
                            if ((eff_w == '0) || (eff_h == '0)) begin
                                n_out_valid = 1'b1;
                                n_out_x     = '0;
                                n_out_y     = '0;
                                n_out_found = 1'b0;
                                n_out_last  = 1'b1;
                                n_start_x   = '0;
                                n_start_y   = '0;
                                n_phase     = PH_DONE;
                            end else begin
                                n_sx         = ONE_C;
                                n_sy         = ONE_C;
                                n_chk        = 1'b0;
                                n_issue_done = 1'b0;
                                n_state      = S_SCAN;
                            end
                        end
                        PH_TRACE: begin
                            // handled by the walker move above
                        end
                        PH_CLOSE: begin
                            n_out_valid = 1'b1;
                            n_out_x     = r_wx;
                            n_out_y     = r_wy;
                            n_out_found = 1'b1;
                            n_out_last  = 1'b1;
                            n_phase     = PH_DONE;
                        end
                        PH_DONE: begin
                            // trace finished, no result
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_start_x = r_cx[COORD_W-1:0] - 9'd1;
                    n_start_y = r_cy[COORD_W-1:0] - 9'd1;
                    n_wx      = r_cx[COORD_W-1:0] - 9'd1;
                    n_wy      = r_cy[COORD_W-1:0] - 9'd1;
                    n_heading = HD_EAST;
                    n_phase   = PH_TRACE;
                    n_state   = S_STEP;
                end else if (r_chk && r_chk_last) begin
                    n_out_valid = 1'b1;
                    n_out_x     = '0;
                    n_out_y     = '0;
                    n_out_found = 1'b0;
                    n_out_last  = 1'b1;
                    n_start_x   = '0;
                    n_start_y   = '0;
                    n_phase     = PH_DONE;
                    n_state     = S_IDLE;
                end else if (!r_issue_done) begin
                    n_chk      = 1'b1;
                    n_cx       = r_sx;
                    n_cy       = r_sy;
                    n_up_in    = (r_sy != ONE_C);
                    n_chk_last = (r_sx == eff_w) && (r_sy == eff_h);
                    if ((r_sx == eff_w) && (r_sy == eff_h)) begin
                        n_issue_done = 1'b1;
                    end else if (r_sx == eff_w) begin
                        n_sx = ONE_C;
                        n_sy = r_sy + ONE_C;
                    end else begin
                        n_sx = r_sx + ONE_C;
                    end
                end else begin
                    n_chk = 1'b0;
                end
            end
            S_STEP: begin
                // handled by the walker move above
            end
            S_TURN: begin
                n_heading = t_heading'(turned);
                if ((r_wx == r_start_x) && (r_wy == r_start_y) && (turned == HD_EAST)) begin
                    n_phase = PH_CLOSE;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // register writes cancel the trace
        if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                n_height = pwdata[COORD_W-1:0];
            end else begin
                n_width = pwdata[COORD_W-1:0];
            end
            n_phase = PH_IDLE;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_IDLE;
            r_heading    <= HD_EAST;
            r_width      <= SIZE_RESET;
            r_height     <= SIZE_RESET;
            r_wx         <= '0;
            r_wy         <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_chk        <= 1'b0;
            r_issue_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_heading    <= n_heading;
            r_width      <= n_width;
            r_height     <= n_height;
            r_wx         <= n_wx;
            r_wy         <= n_wy;
            r_start_x    <= n_start_x;
            r_start_y    <= n_start_y;
            r_chk        <= n_chk;
            r_issue_done <= n_issue_done;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_chk_last  <= n_chk_last;
        r_up_in     <= n_up_in;
        r_l_in      <= n_l_in;
        r_r_in      <= n_r_in;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    // result channel
    assign o_point.valid   = r_out_valid;
    assign o_point.point_x = r_out_x;
    assign o_point.point_y = r_out_y;
    assign o_point.found   = r_out_found;
    assign o_point.last    = r_out_last;

endmodule

// ===== tb/sv/binary_contour_tracer_checker.sv =====
`timescale 1ns / 100ps

module binary_contour_tracer_checker import bct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bct_in_if                     i_item,
    bct_out_if                    i_point,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int SIDE_MAX = 256;

    // one expected corner point
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               found;
        logic               last;
    } t_corner;

    // shadow copy of the image and the walker
    bit                 image_bits [0:SIDE_MAX*SIDE_MAX-1];
    logic [COORD_W-1:0] size_w;
    logic [COORD_W-1:0] size_h;
    logic [COORD_W-1:0] walk_x;
    logic [COORD_W-1:0] walk_y;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    t_heading           walk_dir;
    t_phase             trace_ph;
    t_corner            corner_queue [$];

    // size register clipped to the store
    function automatic int used_span(input logic [COORD_W-1:0] v);
        return (v > SIDE_MAX) ? SIDE_MAX : int'(v);
    endfunction

    // one-based pixel, white outside the image
    function automatic bit pixel_at(input int x, input int y);
        if (x < 1 || y < 1 || x > used_span(size_w) || y > used_span(size_h)) begin
            return 1'b0;
        end
        return image_bits[(y - 1) * SIDE_MAX + (x - 1)];
    endfunction

    // raster scan for a black pixel with a white pixel above
    function automatic bit locate_start();
        for (int y = 1; y <= used_span(size_h); y++) begin
            for (int x = 1; x <= used_span(size_w); x++) begin
                if (pixel_at(x, y) && !pixel_at(x, y - 1)) begin
                    origin_x = COORD_W'(x - 1);
                    origin_y = COORD_W'(y - 1);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // move one corner ahead, then turn on the two pixels in front
    task automatic walk_one();
        int x;
        int y;
        bit lft;
        bit rgt;
        case (walk_dir)
            HD_EAST:  walk_x = walk_x + 1'b1;
            HD_NORTH: walk_y = walk_y - 1'b1;
            HD_WEST:  walk_x = walk_x - 1'b1;
            default:  walk_y = walk_y + 1'b1;
        endcase
        x = int'(walk_x);
        y = int'(walk_y);
        case (walk_dir)
            HD_EAST: begin
                lft = pixel_at(x + 1, y);
                rgt = pixel_at(x + 1, y + 1);
            end
            HD_NORTH: begin
                lft = pixel_at(x, y);
                rgt = pixel_at(x + 1, y);
            end
            HD_WEST: begin
                lft = pixel_at(x, y + 1);
                rgt = pixel_at(x, y);
            end
            default: begin
                lft = pixel_at(x + 1, y + 1);
                rgt = pixel_at(x, y + 1);
            end
        endcase
        if (lft) begin
            walk_dir = t_heading'(walk_dir + 2'd1);
        end else if (!rgt) begin
            walk_dir = t_heading'(walk_dir + 2'd3);
        end
    endtask

    task automatic push_corner(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic found, input logic last);
        t_corner c;
        c.x     = x;
        c.y     = y;
        c.found = found;
        c.last  = last;
        corner_queue.push_back(c);
    endtask

    // pixel write or step request
    task automatic apply_item();
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        px = i_item.pixel_x;
        py = i_item.pixel_y;
        if (i_item.opcode == OP_WRITE) begin
            trace_ph = PH_IDLE;
            if (px >= 1 && py >= 1 && px <= SIDE_MAX && py <= SIDE_MAX) begin
                image_bits[(int'(py) - 1) * SIDE_MAX + int'(px) - 1] = i_item.pixel_black;
            end
            return;
        end
        if (trace_ph == PH_IDLE) begin
            if (!locate_start()) begin
                origin_x = '0;
                origin_y = '0;
                trace_ph = PH_DONE;
                push_corner('0, '0, 1'b0, 1'b1);
                return;
            end
            walk_x   = origin_x;
            walk_y   = origin_y;
            walk_dir = HD_EAST;
            trace_ph = PH_TRACE;
        end
        if (trace_ph == PH_TRACE) begin
            push_corner(walk_x, walk_y, 1'b1, 1'b0);
            walk_one();
            if (walk_x == origin_x && walk_y == origin_y && walk_dir == HD_EAST) begin
                trace_ph = PH_CLOSE;
            end
        end else if (trace_ph == PH_CLOSE) begin
            push_corner(walk_x, walk_y, 1'b1, 1'b1);
            trace_ph = PH_DONE;
        end
    endtask

    function automatic void compare_field(input string tag, input logic [COORD_W-1:0] want,
                                          input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, tag, want, got);
            o_fail_count++;
        end
    endfunction

    // result transfer against the oldest expected corner
    task automatic check_corner();
        t_corner want;
        if (corner_queue.size() == 0) begin
            $display("%0t: unexpected point transfer, expected none, got x=%0d y=%0d found=%0b last=%0b",
                     $time, i_point.point_x, i_point.point_y, i_point.found, i_point.last);
            o_fail_count++;
            return;
        end
        want = corner_queue.pop_front();
        compare_field("point_x", want.x, i_point.point_x);
        compare_field("point_y", want.y, i_point.point_y);
        compare_field("found", want.found, i_point.found);
        compare_field("last", want.last, i_point.last);
    endtask

    // watch the register port and both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_w       = SIZE_RESET;
            size_h       = SIZE_RESET;
            walk_x       = '0;
            walk_y       = '0;
            origin_x     = '0;
            origin_y     = '0;
            walk_dir     = HD_EAST;
            trace_ph     = PH_IDLE;
            o_fail_count = 0;
            corner_queue.delete();
        end else begin
            if (i_point.valid && i_point.ready) begin
                check_corner();
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_WIDTH) begin
                    size_w = pwdata[COORD_W-1:0];
                end else begin
                    size_h = pwdata[COORD_W-1:0];
                end
                trace_ph = PH_IDLE;
            end
            if (i_item.valid && i_item.ready) begin
                apply_item();
            end
        end
        o_pending = corner_queue.size();
    end

endmodule

// ===== tb/sv/binary_contour_tracer_test.sv =====
`timescale 1ns / 100ps

module binary_contour_tracer_test;
    import bct_pkg::*;

    localparam int ITEM_TARGET   = 750;
    localparam int MAX_GAP       = 14;
    localparam int SETTLE_CYCLES = 24;
    localparam int SIDE_MAX      = 256;

    typedef enum int {
        PAT_RECT,
        PAT_NOISE,
        PAT_WHITE,
        PAT_BLACK
    } t_pattern;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bct_in_if  item_ch ();
    bct_out_if point_ch ();

    int fail_count;
    int pending_count;
    int closing_count = 0;
    int items_sent = 0;
    bit no_idle = 1'b0;

    binary_contour_tracer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_point (point_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    binary_contour_tracer_checker point_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_point      (point_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("binary_contour_tracer_test failed");
        $finish;
    end

    // result side: random stall before each transfer, count closing points
    initial begin
        int stall;
        point_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                point_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            point_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!point_ch.valid) @(posedge i_clk);
            if (point_ch.last) begin
                closing_count <= closing_count + 1;
            end
        end
    end

    function automatic int used_span(input logic [COORD_W-1:0] v);
        return (v > SIDE_MAX) ? SIDE_MAX : int'(v);
    endfunction

    // one item transfer after a random gap; valid stays up for a gapless follower
    task automatic send_item(input logic op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic blk, input bit tally);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= op;
        item_ch.pixel_x     <= x;
        item_ch.pixel_y     <= y;
        item_ch.pixel_black <= blk;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (tally) begin
            items_sent++;
        end
    endtask

    // wait for every expected point, then let a trailing write or step finish
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup and access phase; psel stays up for a back-to-back transfer
    task automatic write_register(input logic sel, input logic [COORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FE00) | APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_image_size(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
        settle();
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write every pixel of the image in raster order
    task automatic paint_image(input int cols, input int rows, input t_pattern pat,
                               input bit far);
        int x0;
        int x1;
        int y0;
        int y1;
        bit blk;
        if (cols == 0 || rows == 0) begin
            return;
        end
        x0 = $urandom_range(1, cols);
        y0 = $urandom_range(1, rows);
        x1 = far ? cols : $urandom_range(x0, cols);
        y1 = far ? rows : $urandom_range(y0, rows);
        for (int y = 1; y <= rows; y++) begin
            for (int x = 1; x <= cols; x++) begin
                case (pat)
                    PAT_RECT:  blk = (x >= x0 && x <= x1 && y >= y0 && y <= y1);
                    PAT_NOISE: blk = ($urandom_range(0, 4) < 3);
                    PAT_WHITE: blk = 1'b0;
                    default:   blk = 1'b1;
                endcase
                send_item(OP_WRITE, COORD_W'(x), COORD_W'(y), blk, 1'b1);
            end
        end
    endtask

    // steps until the closing point, with the odd write that restarts the trace
    task automatic trace_contour(input int cols, input int rows);
        int mark;
        int steps;
        int cap;
        int restarts;
        int x;
        int y;
        mark     = closing_count;
        cap      = 4 * (cols + 1) * (rows + 1) + 8;
        steps    = 0;
        restarts = 0;
        while (closing_count == mark && steps < cap) begin
            if (restarts < 2 && $urandom_range(0, 39) == 0) begin
                restarts++;
                steps = 0;
                if (cols > 0 && rows > 0 && $urandom_range(0, 1) == 1) begin
                    // change a pixel inside the image
                    x = $urandom_range(1, cols);
                    y = $urandom_range(1, rows);
                end else begin
                    // coordinate off the store: dropped, trace still restarts
                    x = $urandom_range(0, 511);
                    y = $urandom_range(0, 511);
                    case ($urandom_range(0, 2))
                        0:       x = 0;
                        1:       x = $urandom_range(SIDE_MAX + 1, 511);
                        default: y = ($urandom_range(0, 1) == 1) ? 0
                                   : $urandom_range(SIDE_MAX + 1, 511);
                    endcase
                end
                send_item(OP_WRITE, COORD_W'(x), COORD_W'(y), 1'($urandom()), 1'b1);
            end else begin
                send_item(OP_STEP, COORD_W'($urandom()), COORD_W'($urandom()),
                          1'($urandom()), 1'b1);
                steps++;
            end
        end
        // steps past the closing point get no answer
        repeat ($urandom_range(0, 2)) begin
            send_item(OP_STEP, COORD_W'($urandom()), COORD_W'($urandom()),
                      1'($urandom()), 1'b0);
        end
    endtask

    task automatic random_phase();
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        t_pattern           pat;
        int                 pick;
        w = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(7, 14))
                                        : COORD_W'($urandom_range(1, 6));
        h = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(7, 14))
                                        : COORD_W'($urandom_range(1, 6));
        // now and then a zero size
        if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                w = '0;
            end else begin
                h = '0;
            end
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0:       pat = PAT_WHITE;
            1:       pat = PAT_BLACK;
            2, 3, 4: pat = PAT_RECT;
            default: pat = PAT_NOISE;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
        set_image_size(w, h);
        paint_image(used_span(w), used_span(h), pat, 1'($urandom()));
        trace_contour(used_span(w), used_span(h));
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.opcode      <= OP_WRITE;
        item_ch.pixel_x     <= '0;
        item_ch.pixel_y     <= '0;
        item_ch.pixel_black <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero width: empty result, then a step past done
        set_image_size(9'd0, 9'd1);
        send_item(OP_STEP, 9'd0, 9'd0, 1'b0, 1'b1);
        send_item(OP_STEP, 9'd511, 9'd511, 1'b1, 1'b0);

        // two black pixels touching at a corner
        set_image_size(9'd2, 9'd2);
        send_item(OP_WRITE, 9'd1, 9'd1, 1'b1, 1'b1);
        send_item(OP_WRITE, 9'd2, 9'd1, 1'b0, 1'b1);
        send_item(OP_WRITE, 9'd1, 9'd2, 1'b0, 1'b1);
        send_item(OP_WRITE, 9'd2, 9'd2, 1'b1, 1'b1);
        send_item(OP_STEP, 9'd0, 9'd0, 1'b0, 1'b1);
        send_item(OP_STEP, 9'd0, 9'd0, 1'b0, 1'b1);
        // column 257 would alias pixel (1,1) if the top address bit were lost
        send_item(OP_WRITE, 9'd257, 9'd1, 1'b0, 1'b1);
        send_item(OP_WRITE, 9'd1, 9'd0, 1'b0, 1'b1);
        send_item(OP_WRITE, 9'd511, 9'd511, 1'b1, 1'b1);
        trace_contour(2, 2);

        // saturated size: a full row or a full column
        if ($urandom_range(0, 1) == 1) begin
            set_image_size(9'd511, 9'd1);
            paint_image(SIDE_MAX, 1, PAT_RECT, 1'b1);
            trace_contour(SIDE_MAX, 1);
        end else begin
            set_image_size(9'd1, 9'd300);
            paint_image(1, SIDE_MAX, PAT_RECT, 1'b1);
            trace_contour(1, SIDE_MAX);
        end

        // random images
        while (items_sent < ITEM_TARGET) begin
            random_phase();
        end

        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("binary_contour_tracer_test passed");
        end else begin
            $display("binary_contour_tracer_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bct_pkg.sv
rtl/core/bct_ifs.sv
rtl/core/bct_ram.sv
rtl/core/binary_contour_tracer.sv
tb/sv/binary_contour_tracer_checker.sv
tb/sv/binary_contour_tracer_test.sv
